/* rtl/boolean_query_line_filter_unit_assert.svh */
// Assertion macros for the boolean query line filter unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BOOLEAN_QUERY_LINE_FILTER_UNIT_ASSERT_SVH
`define BOOLEAN_QUERY_LINE_FILTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge, off while reset is high.
`define BQLF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// Checked on every rising clock edge, reset included.
`define BQLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);
`else
`define BQLF_ASSERT(lbl, clk, rst, prop, msg)
`define BQLF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/bqlf_pkg.sv */
// Shared types, codes and helpers of the boolean query line filter unit.
// Used by bqlf_cell and boolean_query_line_filter_unit; depends on nothing.
package bqlf_pkg;

   localparam int MAX_TERMS_DEF    = 8;
   localparam int MAX_TERM_LEN_DEF = 16;
   localparam int MAX_GROUPS_DEF   = 4;

   localparam int CHAR_W    = 16;
   localparam int INDEX_W   = 3;
   localparam int POS_W     = 4;
   localparam int TLEN_W    = 5;
   localparam int GROUP_W   = 2;
   localparam int MASK_W    = 8;
   localparam int ACTIVE_W  = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FUZZY_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_TERMS = 1'b1;

   typedef enum logic [1:0] {
      CMD_TERM_CHAR = 2'd0,
      CMD_TERM_ATTR = 2'd1,
      CMD_LINE_CHAR = 2'd2,
      CMD_LINE_END  = 2'd3
   } cmd_type;

   // One command beat as it travels down the chain of cells.
   typedef struct packed {
      cmd_type                  cmd;
      logic [INDEX_W-1:0]       term_index;
      logic [POS_W-1:0]         char_pos;
      logic [CHAR_W-1:0]        char_value;
      logic [TLEN_W-1:0]        term_length;
      logic [GROUP_W-1:0]       term_group;
      logic                     term_negate;
   } beat_type;

   // Case folding covers ASCII upper-case letters only.
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 16'h0041 && c <= 16'h005A) begin
         r = c + 16'h0020;
      end
      return r;
   endfunction

endpackage

/* rtl/boolean_query_line_filter_unit.sv */
// Top level of the boolean query line filter: CSRs, beat normalization, the chain
// of term cells and the result register. Depends on bqlf_pkg, bqlf_cell and the assert header.
//
// The unit takes one beat per cycle while req_ready is high and reports one
// result per line end. Each beat walks down a chain of MAX_TERMS term cells,
// one cell per cycle unless stalled; a cell applies term writes addressed to
// it, steps its shift-and vector and subsequence pointer on a line character,
// and adds its hit and group verdict on a line end. A line-end result is
// registered in each cell, then waits in the result register; the chain keeps
// taking beats until a second line end waits at its last cell and the cells
// behind are full. Term characters are held folded to lower case, undefined
// until written; cell beats and results are not reset, the rest resets to zero.
// The user writes CSRs only while no beats are in flight; this is not enforced.
`include "boolean_query_line_filter_unit_assert.svh"

module boolean_query_line_filter_unit #(
   parameter int MAX_TERMS    = bqlf_pkg::MAX_TERMS_DEF,
   parameter int MAX_TERM_LEN = bqlf_pkg::MAX_TERM_LEN_DEF,
   parameter int MAX_GROUPS   = bqlf_pkg::MAX_GROUPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic [bqlf_pkg::INDEX_W-1:0]    req_term_index,
   input  logic [bqlf_pkg::POS_W-1:0]      req_char_pos,
   input  logic [bqlf_pkg::CHAR_W-1:0]     req_char_value,
   input  logic [bqlf_pkg::TLEN_W-1:0]     req_term_length,
   input  logic [bqlf_pkg::GROUP_W-1:0]    req_term_group,
   input  logic                            req_term_negate,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_line_match,
   output logic [bqlf_pkg::MASK_W-1:0]     rsp_hit_mask,
   input  logic                            csr_we,
   input  logic [bqlf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bqlf_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import bqlf_pkg::*;

   logic                  fuzzy_ff, fuzzy_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_match_ff;
   logic [MASK_W-1:0]     rsp_mask_ff;

   logic                  chain_valid [MAX_TERMS+1];
   logic                  chain_ready [MAX_TERMS+1];
   beat_type              chain_beat [MAX_TERMS+1];
   logic [MAX_TERMS-1:0]  chain_hits [MAX_TERMS+1];
   logic [MAX_GROUPS-1:0] chain_present [MAX_TERMS+1];
   logic [MAX_GROUPS-1:0] chain_failed [MAX_TERMS+1];

   beat_type              head_beat;
   logic [GROUP_W-1:0]    group_mod;
   logic                  tail_end;
   logic                  tail_take;
   logic [MAX_TERMS+MASK_W-1:0] hits_wide;

   always_comb begin
      fuzzy_in  = fuzzy_ff;
      active_in = active_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FUZZY_MODE:   fuzzy_in  = csr_wdata[0];
            CSR_ACTIVE_TERMS: active_in = csr_wdata[ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Characters are folded once here, lengths saturated and groups reduced.
   always_comb begin
      group_mod = req_term_group;
      for (int i = 0; i < 3; i++) begin
         if (int'(group_mod) >= MAX_GROUPS) begin
            group_mod = group_mod - GROUP_W'(MAX_GROUPS);
         end
      end
      head_beat.cmd         = cmd_type'(req_cmd);
      head_beat.term_index  = req_term_index;
      head_beat.char_pos    = req_char_pos;
      head_beat.char_value  = fold_char(req_char_value);
      head_beat.term_length = (int'(req_term_length) > MAX_TERM_LEN) ?
                              TLEN_W'(MAX_TERM_LEN) : req_term_length;
      head_beat.term_group  = group_mod;
      head_beat.term_negate = req_term_negate;
   end

   assign chain_valid[0]   = req_valid;
   assign req_ready        = chain_ready[0];
   assign chain_beat[0]    = head_beat;
   assign chain_hits[0]    = '0;
   assign chain_present[0] = '0;
   assign chain_failed[0]  = '0;

   for (genvar t = 0; t < MAX_TERMS; t++) begin : g_cell
      bqlf_cell #(
         .CELL_ID      (t),
         .MAX_TERMS    (MAX_TERMS),
         .MAX_TERM_LEN (MAX_TERM_LEN),
         .MAX_GROUPS   (MAX_GROUPS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .fuzzy_mode   (fuzzy_ff),
         .active_terms (active_ff),
         .up_valid     (chain_valid[t]),
         .up_ready     (chain_ready[t]),
         .up_beat      (chain_beat[t]),
         .up_hits      (chain_hits[t]),
         .up_present   (chain_present[t]),
         .up_failed    (chain_failed[t]),
         .dn_valid     (chain_valid[t+1]),
         .dn_ready     (chain_ready[t+1]),
         .dn_beat      (chain_beat[t+1]),
         .dn_hits      (chain_hits[t+1]),
         .dn_present   (chain_present[t+1]),
         .dn_failed    (chain_failed[t+1])
      );
   end

   // Only line-end beats leave the chain as results; the others are dropped here.
   assign tail_end                = chain_beat[MAX_TERMS].cmd == CMD_LINE_END;
   assign chain_ready[MAX_TERMS]  = !tail_end || !rsp_valid_ff || rsp_ready;
   assign tail_take               = chain_valid[MAX_TERMS] && chain_ready[MAX_TERMS] && tail_end;
   assign hits_wide               = {{MASK_W{1'b0}}, chain_hits[MAX_TERMS]};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tail_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fuzzy_ff     <= 1'b0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fuzzy_ff     <= fuzzy_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_take) begin
         rsp_match_ff <= (active_ff == '0) ||
                         ((chain_present[MAX_TERMS] & ~chain_failed[MAX_TERMS]) != '0);
         rsp_mask_ff  <= hits_wide[MASK_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_match = rsp_match_ff;
   assign rsp_hit_mask   = rsp_mask_ff;

   `BQLF_ASSERT(a_empty_output_ready, clock, reset, !rsp_valid_ff |-> req_ready, "chain stalled with an empty result register")
   `BQLF_ASSERT(a_line_end_reported, clock, reset, tail_take |=> rsp_valid_ff, "line end left the chain without a result")
   `BQLF_ASSERT(a_result_retired, clock, reset, rsp_valid_ff && rsp_ready && !tail_take |=> !rsp_valid_ff, "taken result still shown")

endmodule

/* rtl/bqlf_cell.sv */
// One term cell of the boolean query line filter chain: term text, attributes,
// shift-and vector and subsequence pointer. Depends on bqlf_pkg and the assert header.
`include "boolean_query_line_filter_unit_assert.svh"

module bqlf_cell #(
   parameter int CELL_ID      = 0,
   parameter int MAX_TERMS    = bqlf_pkg::MAX_TERMS_DEF,
   parameter int MAX_TERM_LEN = bqlf_pkg::MAX_TERM_LEN_DEF,
   parameter int MAX_GROUPS   = bqlf_pkg::MAX_GROUPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fuzzy_mode,
   input  logic [bqlf_pkg::ACTIVE_W-1:0]   active_terms,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  bqlf_pkg::beat_type              up_beat,
   input  logic [MAX_TERMS-1:0]            up_hits,
   input  logic [MAX_GROUPS-1:0]           up_present,
   input  logic [MAX_GROUPS-1:0]           up_failed,
   output logic                            dn_valid,
   input  logic                            dn_ready,
   output bqlf_pkg::beat_type              dn_beat,
   output logic [MAX_TERMS-1:0]            dn_hits,
   output logic [MAX_GROUPS-1:0]           dn_present,
   output logic [MAX_GROUPS-1:0]           dn_failed
);
   import bqlf_pkg::*;

   localparam int L     = MAX_TERM_LEN;
   localparam int LEN_W = $clog2(MAX_TERM_LEN + 1);
   localparam int IDX_W = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;

   logic [CHAR_W-1:0]     chars_ff [L];
   logic [CHAR_W-1:0]     chars_in [L];
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [GROUP_W-1:0]    group_ff, group_in;
   logic                  negate_ff, negate_in;
   logic [L-1:0]          pmv_ff, pmv_in;
   logic [LEN_W-1:0]      ptr_ff, ptr_in;
   logic                  sticky_ff, sticky_in;
   logic                  valid_ff, valid_in;
   beat_type              beat_ff;
   logic [MAX_TERMS-1:0]  hits_ff, hits_in;
   logic [MAX_GROUPS-1:0] present_ff, present_in;
   logic [MAX_GROUPS-1:0] failed_ff, failed_in;

   logic                  take;
   logic                  sel;
   logic                  cell_on;
   logic [L-1:0]          eq;
   logic [L-1:0]          shift_vec;
   logic                  last_hit;
   logic                  ptr_step;
   logic                  hit_line;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;
   assign sel      = int'(up_beat.term_index) == CELL_ID;
   assign cell_on  = int'(active_terms) > CELL_ID;

   // Match engines: every stored character against the incoming line character.
   always_comb begin
      eq       = '0;
      last_hit = 1'b0;
      for (int k = 0; k < L; k++) begin
         if (LEN_W'(k) < len_ff && chars_ff[k] == up_beat.char_value) begin
            eq[k] = 1'b1;
         end
      end
      shift_vec = ((pmv_ff << 1) | L'(1)) & eq;
      for (int k = 0; k < L; k++) begin
         if (LEN_W'(k + 1) == len_ff) begin
            last_hit = last_hit | shift_vec[k];
         end
      end
      ptr_step = (ptr_ff < len_ff) && eq[ptr_ff[IDX_W-1:0]];
      hit_line = (len_ff == '0) || sticky_ff || (fuzzy_mode && ptr_ff >= len_ff);
   end

   always_comb begin
      chars_in  = chars_ff;
      len_in    = len_ff;
      group_in  = group_ff;
      negate_in = negate_ff;
      pmv_in    = pmv_ff;
      ptr_in    = ptr_ff;
      sticky_in = sticky_ff;
      valid_in  = up_ready ? up_valid : valid_ff;
      if (take) begin
         case (up_beat.cmd)
            CMD_TERM_CHAR: begin
               if (sel) begin
                  for (int k = 0; k < L; k++) begin
                     if (int'(up_beat.char_pos) == k) begin
                        chars_in[k] = up_beat.char_value;
                     end
                  end
               end
            end
            CMD_TERM_ATTR: begin
               if (sel) begin
                  len_in    = LEN_W'(up_beat.term_length);
                  group_in  = up_beat.term_group;
                  negate_in = up_beat.term_negate;
               end
            end
            CMD_LINE_CHAR: begin
               pmv_in = shift_vec;
               if (!fuzzy_mode && last_hit) begin
                  sticky_in = 1'b1;
               end
               if (ptr_step) begin
                  ptr_in = ptr_ff + LEN_W'(1);
               end
            end
            default: begin
               pmv_in    = '0;
               ptr_in    = '0;
               sticky_in = 1'b0;
            end
         endcase
      end
   end

   // Line-end summary: this term adds its hit and its group verdict.
   always_comb begin
      hits_in    = up_hits;
      present_in = up_present;
      failed_in  = up_failed;
      if (cell_on && hit_line) begin
         hits_in[CELL_ID] = 1'b1;
      end
      for (int g = 0; g < MAX_GROUPS; g++) begin
         if (cell_on && int'(group_ff) == g) begin
            present_in[g] = 1'b1;
            if (hit_line == negate_ff) begin
               failed_in[g] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         group_ff  <= '0;
         negate_ff <= 1'b0;
         pmv_ff    <= '0;
         ptr_ff    <= '0;
         sticky_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         len_ff    <= len_in;
         group_ff  <= group_in;
         negate_ff <= negate_in;
         pmv_ff    <= pmv_in;
         ptr_ff    <= ptr_in;
         sticky_ff <= sticky_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (take) begin
         beat_ff    <= up_beat;
         hits_ff    <= hits_in;
         present_ff <= present_in;
         failed_ff  <= failed_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_beat    = beat_ff;
   assign dn_hits    = hits_ff;
   assign dn_present = present_ff;
   assign dn_failed  = failed_ff;

   `BQLF_ASSERT(a_line_end_clears, clock, reset, take && up_beat.cmd == CMD_LINE_END |=> ptr_ff == '0 && !sticky_ff && pmv_ff == '0, "line state not cleared after line end")
   `BQLF_ASSERT(a_sticky_substring_only, clock, reset, $rose(sticky_ff) |-> !$past(fuzzy_mode), "substring hit latched in fuzzy mode")
   `BQLF_ASSERT(a_stage_holds, clock, reset, valid_ff && !dn_ready |=> valid_ff && $stable(beat_ff), "stalled cell stage lost its beat")

endmodule
